// ===== sv/qjet_pkg.sv =====
package qjet_pkg;

   localparam int WORD_BITS = 48;
   localparam int FRAC_BITS = 32;
   localparam int HALF_BITS = WORD_BITS / 2;
   localparam int PART_BITS = HALF_BITS + 1;
   localparam int PROD_BITS = 2 * PART_BITS;
   localparam int ACC_BITS  = 2 * WORD_BITS + 4;
   localparam int STEP_BITS = 16;
   localparam int RAD_BITS  = 47;
   localparam int CSR_IDX_BITS = 3;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [ACC_BITS-1:0]  acc_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_C_W    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_C_X    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_C_Y    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_C_Z    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RADIUS = 3'd5;

   // Phases of one iteration step.
   localparam logic [1:0] PH_DERIV = 2'd0;
   localparam logic [1:0] PH_POINT = 2'd1;
   localparam logic [1:0] PH_ESC   = 2'd2;

   typedef struct packed {
      logic       load;
      logic       mac_en;
      logic       acc_clr;
      logic       wb_en;
      logic       commit_d;
      logic       commit_p;
      logic       out_load;
      logic [1:0] phase;
      logic [1:0] k;
      logic [2:0] t;
      logic [1:0] q;
   } cmd_type;

   typedef struct packed {
      logic                 escaped;
      logic [STEP_BITS-1:0] limit;
   } status_type;

   // Sign of term t of Hamilton product component k.
   function automatic logic term_neg(input logic [1:0] k, input logic [1:0] t);
      logic r;
      unique case (k)
         2'd0: r = (t != 2'd0);
         2'd1: r = (t == 2'd3);
         2'd2: r = (t == 2'd1);
         default: r = (t == 2'd2);
      endcase
      return r;
   endfunction

   // Floor shift by the fraction width, then saturate to the word range.
   function automatic word_type sat_shift(input acc_type a);
      logic [ACC_BITS-FRAC_BITS-1:0] s;
      word_type r;
      s = a[ACC_BITS-1:FRAC_BITS];
      if (&s[ACC_BITS-FRAC_BITS-1:WORD_BITS-1] || ~|s[ACC_BITS-FRAC_BITS-1:WORD_BITS-1]) begin
         r = s[WORD_BITS-1:0];
      end else if (s[ACC_BITS-FRAC_BITS-1]) begin
         r = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(WORD_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   // Saturating sum of two words.
   function automatic word_type sat_add(input word_type a, input word_type b);
      logic signed [WORD_BITS:0] s;
      word_type r;
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (s[WORD_BITS] == s[WORD_BITS-1]) begin
         r = s[WORD_BITS-1:0];
      end else if (s[WORD_BITS]) begin
         r = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(WORD_BITS-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== sv/qjet_datapath.sv =====
module qjet_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  qjet_pkg::cmd_type                      cmd,
   output qjet_pkg::status_type                   status,
   input  logic                                   csr_we,
   input  logic [qjet_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [qjet_pkg::WORD_BITS-1:0]         csr_data,
   input  logic [8*qjet_pkg::WORD_BITS-1:0]       in_data,
   output logic [8*qjet_pkg::WORD_BITS-1:0]       out_data
);
   import qjet_pkg::*;

   word_type             c_ff [4];
   word_type             c_in [4];
   logic [STEP_BITS-1:0] limit_ff, limit_in;
   logic [RAD_BITS-1:0]  radius_ff, radius_in;
   word_type             p_ff [4];
   word_type             p_in [4];
   word_type             d_ff [4];
   word_type             d_in [4];
   word_type             tq_ff [4];
   word_type             tq_in [4];
   word_type             out_ff [8];
   word_type             out_in [8];
   acc_type              acc_ff, acc_in;

   word_type                     a_op, b_op;
   logic                         neg;
   logic signed [PART_BITS-1:0]  a_part, b_part;
   logic signed [PROD_BITS-1:0]  prod;
   acc_type                      prod_ext, shifted, contrib;
   logic [1:0]                   ti;

   assign ti = cmd.t[1:0];

   // Operand selection for the shared multiplier.
   always_comb begin
      a_op = p_ff[ti];
      b_op = p_ff[ti];
      neg  = 1'b0;
      unique case (cmd.phase)
         PH_DERIV: begin
            a_op = d_ff[ti];
            b_op = p_ff[cmd.k ^ ti];
            neg  = term_neg(cmd.k, ti);
         end
         PH_POINT: begin
            a_op = p_ff[ti];
            b_op = p_ff[cmd.k ^ ti];
            neg  = term_neg(cmd.k, ti);
         end
         default: begin
            if (cmd.t == 3'd4) begin
               a_op = {1'b0, radius_ff};
               b_op = {1'b0, radius_ff};
               neg  = 1'b1;
            end
         end
      endcase
   end

   // One signed 25x25 partial product per cycle while mac_en is set, accumulated at its weight.
   always_comb begin
      a_part   = cmd.q[0] ? {a_op[WORD_BITS-1], a_op[WORD_BITS-1:HALF_BITS]}
                          : {1'b0, a_op[HALF_BITS-1:0]};
      b_part   = cmd.q[1] ? {b_op[WORD_BITS-1], b_op[WORD_BITS-1:HALF_BITS]}
                          : {1'b0, b_op[HALF_BITS-1:0]};
      prod     = a_part * b_part;
      prod_ext = {{(ACC_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
      unique case (cmd.q)
         2'd0:    shifted = prod_ext;
         2'd3:    shifted = prod_ext <<< (2 * HALF_BITS);
         default: shifted = prod_ext <<< HALF_BITS;
      endcase
      contrib = neg ? -shifted : shifted;
      acc_in  = acc_ff;
      if (cmd.mac_en) begin
         acc_in = (cmd.acc_clr ? '0 : acc_ff) + contrib;
      end
   end

   always_comb begin
      c_in      = c_ff;
      limit_in  = limit_ff;
      radius_in = radius_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_C_W:    c_in[0]   = csr_data;
            CSR_C_X:    c_in[1]   = csr_data;
            CSR_C_Y:    c_in[2]   = csr_data;
            CSR_C_Z:    c_in[3]   = csr_data;
            CSR_LIMIT:  limit_in  = csr_data[STEP_BITS-1:0];
            CSR_RADIUS: radius_in = csr_data[RAD_BITS-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      p_in   = p_ff;
      d_in   = d_ff;
      tq_in  = tq_ff;
      out_in = out_ff;
      if (cmd.wb_en) begin
         tq_in[cmd.k] = sat_shift(acc_ff);
      end
      for (int i = 0; i < 4; i++) begin
         if (cmd.load) begin
            p_in[i] = in_data[i*WORD_BITS +: WORD_BITS];
            d_in[i] = in_data[(i+4)*WORD_BITS +: WORD_BITS];
         end
         if (cmd.commit_d) begin
            d_in[i] = sat_add(tq_ff[i], tq_ff[i]);
         end
         if (cmd.commit_p) begin
            p_in[i] = sat_add(tq_ff[i], c_ff[i]);
         end
         if (cmd.out_load) begin
            out_in[i]     = p_ff[i];
            out_in[i + 4] = d_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            c_ff[i] <= '0;
         end
         limit_ff  <= STEP_BITS'(64);
         radius_ff <= RAD_BITS'(64'd17179869184);
      end else begin
         c_ff      <= c_in;
         limit_ff  <= limit_in;
         radius_ff <= radius_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      d_ff   <= d_in;
      tq_ff  <= tq_in;
      out_ff <= out_in;
      acc_ff <= acc_in;
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         out_data[i*WORD_BITS +: WORD_BITS] = out_ff[i];
      end
   end

   // Sum of squares minus squared radius, strictly positive means escaped.
   assign status.escaped = !acc_ff[ACC_BITS-1] && (acc_ff != '0);
   assign status.limit   = limit_ff;

endmodule

// ===== sv/qjet_control.sv =====
module qjet_control (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_fire,
   output logic                             req_ready,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [qjet_pkg::STEP_BITS-1:0]   escape_step,
   input  qjet_pkg::status_type             status,
   output qjet_pkg::cmd_type                cmd
);
   import qjet_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RUN    = 3'd1;
   localparam logic [2:0] S_WB     = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           phase_ff, phase_in;
   logic [1:0]           k_ff, k_in;
   logic [2:0]           t_ff, t_in;
   logic [1:0]           q_ff, q_in;
   logic [STEP_BITS-1:0] n_ff, n_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [STEP_BITS-1:0] rsp_step_ff, rsp_step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           t_last;
   logic                 last_step;

   assign t_last    = (phase_ff == PH_ESC) ? 3'd4 : 3'd3;
   assign last_step = ({1'b0, n_ff} + 17'd1) == {1'b0, status.limit};

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      k_in         = k_ff;
      t_in         = t_ff;
      q_in         = q_ff;
      n_in         = n_ff;
      step_in      = step_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.phase    = phase_ff;
      cmd.k        = k_ff;
      cmd.t        = t_ff;
      cmd.q        = q_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               phase_in = PH_DERIV;
               k_in     = '0;
               t_in     = '0;
               q_in     = '0;
               n_in     = '0;
               if (status.limit == '0) begin
                  step_in  = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            cmd.mac_en  = 1'b1;
            cmd.acc_clr = (t_ff == '0) && (q_ff == '0);
            q_in        = q_ff + 2'd1;
            if (q_ff == 2'd3) begin
               if (t_ff == t_last) begin
                  t_in     = '0;
                  state_in = S_WB;
               end else begin
                  t_in = t_ff + 3'd1;
               end
            end
         end
         S_WB: begin
            if (phase_ff == PH_ESC) begin
               if (status.escaped || last_step) begin
                  step_in  = status.escaped ? n_ff : status.limit;
                  state_in = S_DONE;
               end else begin
                  n_in     = n_ff + 1'b1;
                  phase_in = PH_DERIV;
                  state_in = S_RUN;
               end
            end else begin
               cmd.wb_en = 1'b1;
               if (k_ff == 2'd3) begin
                  state_in = S_COMMIT;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_RUN;
               end
            end
         end
         S_COMMIT: begin
            k_in     = '0;
            state_in = S_RUN;
            if (phase_ff == PH_DERIV) begin
               cmd.commit_d = 1'b1;
               phase_in     = PH_POINT;
            end else begin
               cmd.commit_p = 1'b1;
               phase_in     = PH_ESC;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff) begin
               cmd.out_load = 1'b1;
               rsp_step_in  = step_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_DERIV;
         k_ff         <= '0;
         t_ff         <= '0;
         q_ff         <= '0;
         n_ff         <= '0;
         step_ff      <= '0;
         rsp_step_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         k_ff         <= k_in;
         t_ff         <= t_in;
         q_ff         <= q_in;
         n_ff         <= n_in;
         step_ff      <= step_in;
         rsp_step_ff  <= rsp_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign escape_step = rsp_step_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("controller stayed idle after an item was taken");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff)
      else $error("result register overwritten while still pending");

   a_run_to_wb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && q_ff == 2'd3 && t_ff == t_last) |=> state_ff == S_WB)
      else $error("accumulation did not end in write-back");

endmodule

// ===== sv/quaternion_julia_escape_test_unit.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  start point and start derivative
// rsp       out        rsp_tvalid/rsp_tready  escape step, final point, final derivative
// csr       in         csr_valid/csr_ready    register index and write data
//
// Each iteration step computes two Hamilton products (four partial products of
// 25x25 bits per term on one shared multiplier) and then an escape check.
// Reset is synchronous and active high; it restores the register defaults.
// A finished result waits in the output register, and a new item is accepted
// meanwhile; the unit stalls only when a second result is ready before then.
module quaternion_julia_escape_test_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // pt_w, pt_x, pt_y, pt_z, dv_w, dv_x, dv_y, dv_z (48 bits each, lowest first)
   input  logic [8*qjet_pkg::WORD_BITS-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // escape_step (16), end_pt_w, end_pt_x, end_pt_y, end_pt_z,
   // end_dv_w, end_dv_x, end_dv_y, end_dv_z (48 each)
   output logic [qjet_pkg::STEP_BITS+8*qjet_pkg::WORD_BITS-1:0] rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [qjet_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [qjet_pkg::WORD_BITS-1:0]        csr_data
);
   import qjet_pkg::*;

   cmd_type                     cmd;
   status_type                  status;
   logic                        req_fire;
   logic [STEP_BITS-1:0]        escape_step;
   logic [8*WORD_BITS-1:0]      out_data;

   // Registers are always writable; the user must change them only while idle, as the unit does not enforce it.
   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;

   qjet_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_ready   (req_tready),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .escape_step (escape_step),
      .status      (status),
      .cmd         (cmd)
   );

   qjet_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_data   (req_tdata),
      .out_data  (out_data)
   );

   assign rsp_tdata = {out_data, escape_step};

endmodule
